[rtl/core/assert_macros.svh]
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent implies consequent on the following edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/sha1ks_pkg.sv]
package sha1ks_pkg;

  localparam int unsigned SeedWidth = 64;
  localparam int unsigned CfgIdxWidth = 1;
  localparam int unsigned DataWidth = 8;
  localparam int unsigned NumRounds = 80;
  localparam int unsigned RoundWidth = 7;

  localparam logic [CfgIdxWidth-1:0] CfgSeedFirst = 1'b0;
  localparam logic [CfgIdxWidth-1:0] CfgSeedSecond = 1'b1;

  localparam logic [31:0] H0Init = 32'h67452301;
  localparam logic [31:0] H1Init = 32'hEFCDAB89;
  localparam logic [31:0] H2Init = 32'h98BADCFE;
  localparam logic [31:0] H3Init = 32'h10325476;
  localparam logic [31:0] H4Init = 32'hC3D2E1F0;

  typedef struct packed {
    logic [DataWidth-1:0] data;
    logic start;
    logic last;
  } in_item_t;

  typedef struct packed {
    logic [DataWidth-1:0] data;
    logic last;
  } out_item_t;

  typedef enum logic [2:0] {
    StIdle,
    StBlk1,
    StBlk2,
    StOut
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic take_item;   // latch input item and apply restart
    logic init_hash;   // load iv and message block 1
    logic load_pad;    // fold block 1 and load the padding block
    logic round_en;    // one sha-1 round
    logic finish;      // fold block 2 into the keystream
    logic emit;        // xor and advance position
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_refresh;
    logic rounds_done;
  } dp_status_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

endpackage

[rtl/core/sha1ks_stream_if.sv]
interface sha1ks_stream_if #(
  parameter type payload_t = logic
);
  logic valid;
  logic ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/sha1_counter_keystream_xor.sv]
// sha-1 counter-mode keystream xor. each accepted byte leaves xored with the
// keystream byte at the current position; a byte at position zero (or with
// start set, which also clears the block counter) first runs two sha-1
// compressions of 80 rounds each through one shared round unit. the next
// byte is accepted only after the previous result has been loaded into the
// output register, which out_ready can stall. seeds must be written through
// cfg_* only while idle; the block itself does not enforce this.
module sha1_counter_keystream_xor (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [sha1ks_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [sha1ks_pkg::SeedWidth-1:0] cfg_data_i,
  sha1ks_stream_if.sink        in_if,
  sha1ks_stream_if.source      out_if
);

  sha1ks_pkg::ctrl_cmd_t cmd;
  sha1ks_pkg::dp_status_t status;

  // sequencer: accept, optional rehash, emit
  sha1ks_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i  (in_if.valid),
    .in_ready_o  (in_if.ready),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // seeds, counter, sha-1 round unit and output register
  sha1ks_datapath u_dp (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .item_i   (in_if.payload),
    .cmd_i    (cmd),
    .status_o (status),
    .result_o (out_if.payload)
  );

endmodule

[rtl/core/sha1ks_ctrl.sv]
module sha1ks_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  sha1ks_pkg::dp_status_t status_i,
  output sha1ks_pkg::ctrl_cmd_t  cmd_o
);

  sha1ks_pkg::ctrl_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic accept;

  // result register can hold one pending transaction while the next item runs
  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      sha1ks_pkg::StIdle: begin
        if (accept) begin
          state_d = sha1ks_pkg::StOut;
        end
      end
      sha1ks_pkg::StOut: begin
        if (status_i.need_refresh) begin
          state_d = sha1ks_pkg::StBlk1;
        end else if (!out_valid_q || out_ready_i) begin
          state_d = sha1ks_pkg::StIdle;
        end
      end
      sha1ks_pkg::StBlk1: begin
        if (status_i.rounds_done) begin
          state_d = sha1ks_pkg::StBlk2;
        end
      end
      sha1ks_pkg::StBlk2: begin
        if (status_i.rounds_done) begin
          state_d = sha1ks_pkg::StOut;
        end
      end
      default: state_d = sha1ks_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      sha1ks_pkg::StIdle: begin
        in_ready_o = 1'b1;
        cmd_o.take_item = accept;
      end
      sha1ks_pkg::StOut: begin
        if (status_i.need_refresh) begin
          cmd_o.init_hash = 1'b1;
        end else if (!out_valid_q || out_ready_i) begin
          cmd_o.emit = 1'b1;
          out_valid_d = 1'b1;
        end
      end
      sha1ks_pkg::StBlk1: begin
        cmd_o.round_en = !status_i.rounds_done;
        cmd_o.load_pad = status_i.rounds_done;
      end
      sha1ks_pkg::StBlk2: begin
        cmd_o.round_en = !status_i.rounds_done;
        cmd_o.finish = status_i.rounds_done;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha1ks_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[rtl/core/sha1ks_datapath.sv]
module sha1ks_datapath (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [sha1ks_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [sha1ks_pkg::SeedWidth-1:0] cfg_data_i,
  input  sha1ks_pkg::in_item_t   item_i,
  input  sha1ks_pkg::ctrl_cmd_t  cmd_i,
  output sha1ks_pkg::dp_status_t status_o,
  output sha1ks_pkg::out_item_t  result_o
);

  logic [sha1ks_pkg::SeedWidth-1:0] seed0_q, seed1_q;
  logic [63:0] ctr_q;
  logic [3:0] pos_q;
  logic refresh_q;
  sha1ks_pkg::in_item_t item_q;
  sha1ks_pkg::out_item_t result_q;
  logic [127:0] ks_q;
  logic [31:0] a_q, b_q, c_q, d_q, e_q;
  logic [31:0] h_q [5];
  logic [31:0] w_q [16];
  logic [sha1ks_pkg::RoundWidth-1:0] rnd_q;

  logic [511:0] msg;
  logic [31:0] f, k, t, wn, wcur;
  logic [31:0] h1 [5];

  assign msg = {seed0_q, seed0_q, seed1_q, seed1_q, 192'd0, ctr_q};

  assign wcur = w_q[0];
  assign wn = sha1ks_pkg::rotl(w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0], 1);

  always_comb begin
    if (rnd_q < 7'd20) begin
      f = (b_q & c_q) | (~b_q & d_q);
      k = 32'h5A827999;
    end else if (rnd_q < 7'd40) begin
      f = b_q ^ c_q ^ d_q;
      k = 32'h6ED9EBA1;
    end else if (rnd_q < 7'd60) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k = 32'h8F1BBCDC;
    end else begin
      f = b_q ^ c_q ^ d_q;
      k = 32'hCA62C1D6;
    end
    t = sha1ks_pkg::rotl(a_q, 5) + f + e_q + k + wcur;
    h1[0] = h_q[0] + a_q;
    h1[1] = h_q[1] + b_q;
    h1[2] = h_q[2] + c_q;
    h1[3] = h_q[3] + d_q;
    h1[4] = h_q[4] + e_q;
  end

  assign status_o.need_refresh = refresh_q;
  assign status_o.rounds_done =
      (rnd_q == sha1ks_pkg::RoundWidth'(sha1ks_pkg::NumRounds));
  assign result_o = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed0_q <= '0;
      seed1_q <= '0;
      ctr_q <= '0;
      pos_q <= '0;
      refresh_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == sha1ks_pkg::CfgSeedFirst) seed0_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == sha1ks_pkg::CfgSeedSecond) seed1_q <= cfg_data_i;
      if (cmd_i.take_item) begin
        if (item_i.start) begin
          ctr_q <= '0;
          pos_q <= '0;
        end
        refresh_q <= item_i.start || (pos_q == 4'd0);
      end
      if (cmd_i.init_hash) refresh_q <= 1'b0;
      if (cmd_i.emit) begin
        pos_q <= pos_q + 4'd1;
        if (pos_q == 4'hF) ctr_q <= ctr_q + 64'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item) item_q <= item_i;
    if (cmd_i.emit) begin
      result_q.data <= item_q.data ^ ks_q[127 - 8*pos_q -: 8];
      result_q.last <= item_q.last;
    end
    if (cmd_i.init_hash || cmd_i.load_pad) begin
      rnd_q <= '0;
      for (int i = 0; i < 16; i++) begin
        w_q[i] <= cmd_i.init_hash ? msg[511 - 32*i -: 32]
            : (i == 0 ? 32'h80000000 : (i == 15 ? 32'd512 : 32'd0));
      end
    end else if (cmd_i.round_en) begin
      rnd_q <= rnd_q + 7'd1;
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wn;
      a_q <= t;
      b_q <= a_q;
      c_q <= sha1ks_pkg::rotl(b_q, 30);
      d_q <= c_q;
      e_q <= d_q;
    end
    if (cmd_i.init_hash) begin
      h_q[0] <= sha1ks_pkg::H0Init; a_q <= sha1ks_pkg::H0Init;
      h_q[1] <= sha1ks_pkg::H1Init; b_q <= sha1ks_pkg::H1Init;
      h_q[2] <= sha1ks_pkg::H2Init; c_q <= sha1ks_pkg::H2Init;
      h_q[3] <= sha1ks_pkg::H3Init; d_q <= sha1ks_pkg::H3Init;
      h_q[4] <= sha1ks_pkg::H4Init; e_q <= sha1ks_pkg::H4Init;
    end
    if (cmd_i.load_pad) begin
      for (int i = 0; i < 5; i++) h_q[i] <= h1[i];
      a_q <= h1[0]; b_q <= h1[1]; c_q <= h1[2]; d_q <= h1[3]; e_q <= h1[4];
    end
    if (cmd_i.finish) ks_q <= {h1[0], h1[1], h1[2], h1[3]};
  end

endmodule

[rtl/core/sha1ks_checker.sv]
`include "assert_macros.svh"

module sha1ks_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input sha1ks_pkg::out_item_t out_payload
);

  // a stalled result keeps its data
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid && $stable(out_payload), "result dropped or changed while stalled")
  // in_ready drops after every accepted input transaction
  `ASSERT_NEXT(a_in_gap, clk_i, rst_ni, in_valid && in_ready, !in_ready, "input accepted twice in a row")
  // out_valid rises only where $past(in_ready) is low
  `ASSERT_ALWAYS(a_out_cause, clk_i, rst_ni, !$rose(out_valid) || !$past(in_ready), "result without input")

endmodule

bind sha1_counter_keystream_xor sha1ks_checker u_checker (
  .clk_i,
  .rst_ni,
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .out_payload (out_if.payload)
);
